### rtl/svg_tag_sniffer_assert.svh
// Assertion macros for the sniffer RTL, used by svgts_back.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef SVG_TAG_SNIFFER_ASSERT_SVH
`define SVG_TAG_SNIFFER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent
`define SVGTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("svg_tag_sniffer: assertion failed");

// Consequent holds in the cycle after the antecedent
`define SVGTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("svg_tag_sniffer: assertion failed");

`endif

### rtl/svgts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgts_pkg
// Shared types and constants of the SVG start tag sniffer.
// ----------------------------------------------------------------------------
package svgts_pkg;

    localparam int unsigned SCAN_W            = 16;
    localparam logic [SCAN_W-1:0] SCAN_LIMIT_RESET = 16'd8192;
    localparam int unsigned QUEUE_DEPTH_DEF   = 2;
    localparam int unsigned NAME_LEN          = 3;

    // Characters the classifier looks for
    localparam logic [7:0] CH_LT    = 8'h3C; // '<'
    localparam logic [7:0] CH_GT    = 8'h3E; // '>'
    localparam logic [7:0] CH_SLASH = 8'h2F; // '/'
    localparam logic [7:0] CH_COLON = 8'h3A; // ':'
    localparam logic [7:0] CH_QMARK = 8'h3F; // '?'
    localparam logic [7:0] CH_BANG  = 8'h21; // '!'
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_UP_A  = 8'h41; // 'A'
    localparam logic [7:0] CH_UP_Z  = 8'h5A; // 'Z'
    localparam logic [7:0] CH_S     = 8'h73; // 's'
    localparam logic [7:0] CH_V     = 8'h76; // 'v'
    localparam logic [7:0] CH_G     = 8'h67; // 'g'

    // One classified byte, handed from the front end to the tracker
    typedef struct packed {
        logic                in_win;   // byte lies inside the scan window
        logic                close;    // byte closes the window
        logic                last;     // final byte of the buffer
        logic                space;    // whitespace
        logic                term;     // name terminator: '>', '/' or whitespace
        logic                colon;
        logic                lt;
        logic                qb;       // '?' or '!'
        logic [NAME_LEN-1:0] match;    // case-folded byte equals name char k
    } t_cls;

endpackage

### rtl/svgts_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgts_byte_if
// Byte stream channel: valid/ready with one buffer byte and its last flag.
// ----------------------------------------------------------------------------
interface svgts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/svgts_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgts_res_if
// Verdict channel: valid/ready with the is_svg flag.
// ----------------------------------------------------------------------------
interface svgts_res_if;
    logic valid;
    logic ready;
    logic is_svg;

    modport source (output valid, output is_svg, input ready);
    modport sink   (input valid, input is_svg, output ready);
endinterface

### rtl/svgts_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgts_cfg_if
// Configuration write channel: valid/ready with the scan limit value.
// ----------------------------------------------------------------------------
interface svgts_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/svgts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgts_front
// Accepts bytes, tracks the window position and classifies each byte.
// ----------------------------------------------------------------------------
module svgts_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    svgts_cfg_if.sink          i_cfg,
    svgts_byte_if.sink         i_in,
    input  logic               i_push_ready,
    output logic               o_push_valid,
    output svgts_pkg::t_cls    o_push_data
);
    import svgts_pkg::*;

    logic [SCAN_W-1:0] r_limit, n_limit;
    logic [SCAN_W-1:0] r_pos,   n_pos;
    logic [SCAN_W:0]   pos_inc;
    logic [7:0]        c;
    logic [7:0]        lc;
    logic              accept;
    t_cls              cls;

    assign i_cfg.ready  = 1'b1;
    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;
    assign accept       = i_in.valid && i_push_ready;
    assign c            = i_in.data_byte;

    // Fold upper case letters to lower case
    assign lc = (c >= CH_UP_A && c <= CH_UP_Z) ? (c | 8'h20) : c;

    // Classify the byte and mark its place in the window
    always_comb begin
        pos_inc      = {1'b0, r_pos} + {{SCAN_W{1'b0}}, 1'b1};
        cls.in_win   = (r_pos < r_limit);
        cls.close    = cls.in_win && ((pos_inc == {1'b0, r_limit}) || i_in.last_byte);
        cls.last     = i_in.last_byte;
        cls.space    = (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
        cls.term     = cls.space || (c == CH_GT) || (c == CH_SLASH);
        cls.colon    = (c == CH_COLON);
        cls.lt       = (c == CH_LT);
        cls.qb       = (c == CH_QMARK) || (c == CH_BANG);
        cls.match[0] = (lc == CH_S);
        cls.match[1] = (lc == CH_V);
        cls.match[2] = (lc == CH_G);
    end

    assign o_push_data = cls;

    // Next window position and scan limit
    always_comb begin
        n_limit = r_limit;
        n_pos   = r_pos;
        if (i_cfg.valid) begin
            n_limit = i_cfg.data;
        end
        if (accept) begin
            if (i_in.last_byte) begin
                n_pos = '0;
            end else if (cls.in_win) begin
                n_pos = pos_inc[SCAN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= SCAN_LIMIT_RESET;
            r_pos   <= '0;
        end else begin
            r_limit <= n_limit;
            r_pos   <= n_pos;
        end
    end

endmodule

### rtl/svgts_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgts_queue
// Short FIFO of classified bytes between the front end and the tracker.
// ----------------------------------------------------------------------------
module svgts_queue #(
    parameter int unsigned DEPTH = svgts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_valid,
    output logic               o_push_ready,
    input  svgts_pkg::t_cls    i_push_data,
    output logic               o_pop_valid,
    input  logic               i_pop_ready,
    output svgts_pkg::t_cls    o_pop_data
);
    import svgts_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cls          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          push, pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers with wrap and update the fill count
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Hold the payload entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

### rtl/svgts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgts_back
// Tag tracker: advances the live tracker set per byte and emits the verdict.
// ----------------------------------------------------------------------------
module svgts_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pop_valid,
    output logic               o_pop_ready,
    input  svgts_pkg::t_cls    i_pop_data,
    svgts_res_if.source        o_res
);
    import svgts_pkg::*;

    `include "svg_tag_sniffer_assert.svh"

    // Tracker bit positions: whitespace skip, name before ':' with k matched,
    // mismatched name before ':', name after ':' with k matched
    localparam int unsigned LW    = 10;
    localparam int unsigned B_WS  = 0;
    localparam int unsigned B_B0  = 1;
    localparam int unsigned B_BAD = 5;
    localparam int unsigned B_C0  = 6;

    logic [LW-1:0] r_live, n_live;
    logic          r_found, n_found;
    logic          r_out_valid, n_out_valid;
    logic          r_is_svg, n_is_svg;
    logic [3:0]    bset;
    logic [LW-1:0] nx;
    logic          hit;
    logic          pop;
    t_cls          it;

    assign it          = i_pop_data;
    assign o_pop_ready = !it.last || !r_out_valid || o_res.ready;
    assign pop         = i_pop_valid && o_pop_ready;

    // One step of the tracker set
    always_comb begin
        nx   = '0;
        hit  = 1'b0;
        bset = r_live[B_B0 +: 4];
        if (r_live[B_WS]) begin
            if (it.space) begin
                nx[B_WS] = 1'b1;
            end else if (!it.qb) begin
                bset[0] = 1'b1;
            end
        end
        for (int k = 0; k < 4; k++) begin
            if (bset[k]) begin
                if (it.colon) begin
                    nx[B_C0] = 1'b1;
                end else if (it.term) begin
                    if (k == NAME_LEN) begin
                        hit = 1'b1;
                    end
                end else if (k < NAME_LEN && it.match[k[1:0]]) begin
                    nx[B_B0 + k + 1] = 1'b1;
                end else begin
                    nx[B_BAD] = 1'b1;
                end
            end
        end
        if (r_live[B_BAD]) begin
            if (it.colon) begin
                nx[B_C0] = 1'b1;
            end else if (!it.term) begin
                nx[B_BAD] = 1'b1;
            end
        end
        for (int k = 0; k < 4; k++) begin
            if (r_live[B_C0 + k]) begin
                if (it.term) begin
                    if (k == NAME_LEN) begin
                        hit = 1'b1;
                    end
                end else if (k < NAME_LEN && it.match[k[1:0]]) begin
                    nx[B_C0 + k + 1] = 1'b1;
                end
            end
        end
        if (it.lt) begin
            nx[B_WS] = 1'b1;
        end
    end

    // Apply the step, close the window and produce the verdict
    always_comb begin
        n_live      = r_live;
        n_found     = r_found;
        n_out_valid = r_out_valid && !o_res.ready;
        n_is_svg    = r_is_svg;
        if (pop) begin
            if (it.in_win) begin
                n_live  = nx;
                n_found = r_found || hit;
                if (it.close) begin
                    n_found = n_found || nx[B_B0 + 3] || nx[B_C0 + 3];
                    n_live  = '0;
                end
            end
            if (it.last) begin
                n_out_valid = 1'b1;
                n_is_svg    = n_found;
                n_found     = 1'b0;
                n_live      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_is_svg    <= 1'b0;
        end else begin
            r_live      <= n_live;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            r_is_svg    <= n_is_svg;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.is_svg = r_is_svg;

    `SVGTS_ASSERT_NEXT(a_close_clears, i_clk, i_rst_n,
        pop && it.in_win && it.close, r_live == '0)
    `SVGTS_ASSERT_NEXT(a_last_verdict, i_clk, i_rst_n,
        pop && it.last, o_res.valid && !r_found && r_live == '0)
    `SVGTS_ASSERT_NEXT(a_outside_hold, i_clk, i_rst_n,
        pop && !it.in_win && !it.last, $stable(r_live) && $stable(r_found))
    `SVGTS_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n,
        r_out_valid && !o_res.ready && i_pop_valid && it.last, !o_pop_ready)

endmodule

### rtl/svg_tag_sniffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svg_tag_sniffer
// Streaming detector for an SVG start tag in the leading bytes of a buffer.
// ----------------------------------------------------------------------------
// Bytes enter on i_in at one per clock cycle, with no bubbles between buffers,
// while the verdict output keeps up. Only the first scan_limit bytes (8192
// after reset) are examined; the user must write it on i_cfg only while the
// block is idle, which the block does not enforce. Exactly one verdict leaves
// on o_res for the byte marked last_byte, valid from the clock edge that moves
// that byte out of the internal queue. The tracker set takes one classified
// byte per cycle unless a last byte waits on an untaken verdict; a queue of
// QUEUE_DEPTH entries decouples byte acceptance from a stalled verdict output.
module svg_tag_sniffer #(
    parameter int unsigned QUEUE_DEPTH = svgts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    svgts_cfg_if.sink    i_cfg,
    svgts_byte_if.sink   i_in,
    svgts_res_if.source  o_res
);
    import svgts_pkg::*;

    logic push_valid, push_ready;
    logic pop_valid,  pop_ready;
    t_cls push_data,  pop_data;

    // Accept and classify
    svgts_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_in         (i_in),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_data  (push_data)
    );

    // Decouple front and back
    svgts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    // Track candidates and deliver the verdict
    svgts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_res       (o_res)
    );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SVG start tag sniffer. Streams byte buffers
// through the byte channel under several scan limits, predicts each verdict
// with a bit-level tracker model and checks every verdict in order. Both
// channels idle at random. One long output hold-off backs the block up into
// its input.
// ----------------------------------------------------------------------------
module testbench;
    import svgts_pkg::*;

    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned MAX_BUF_LEN  = 60;

    // Tracker bit positions: whitespace skip, name chars before ':',
    // mismatched name, name chars after ':'
    localparam int TRK_WS    = 0;
    localparam int TRK_NAME  = 1;
    localparam int TRK_BAD   = 5;
    localparam int TRK_LOCAL = 6;

    localparam logic [7:0] CH_LO_A = 8'h61; // 'a'
    localparam logic [7:0] CH_LO_Z = 8'h7A; // 'z'
    localparam logic [7:0] CASE_BIT = 8'h20;

    // ------------------------------------------------------------------------
    // Verdict predictor and in-order checker
    // ------------------------------------------------------------------------
    class verdict_board;
        logic [SCAN_W-1:0] scan_limit;
        logic [9:0]        live;
        logic [SCAN_W-1:0] position;
        bit                found;
        bit                verdicts_due[$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       positives;

        function new();
            scan_limit = SCAN_LIMIT_RESET;
            mismatches = 0;
            checked    = 0;
            positives  = 0;
            clear_buffer();
        endfunction

        function void clear_buffer();
            live     = '0;
            position = '0;
            found    = 1'b0;
        endfunction

        function void set_limit(logic [SCAN_W-1:0] value);
            scan_limit = value;
        endfunction

        function bit is_space(logic [7:0] c);
            return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
        endfunction

        function bit is_term(logic [7:0] c);
            return c == CH_GT || c == CH_SLASH || is_space(c);
        endfunction

        function logic [7:0] name_char(int k);
            case (k)
                0:       return CH_S;
                1:       return CH_V;
                default: return CH_G;
            endcase
        endfunction

        // Advance every live tracker by one byte; a completed name sets found
        function logic [9:0] step_trackers(logic [9:0] cur, logic [7:0] c);
            logic [9:0] nx;
            logic [9:0] opened;
            logic [7:0] lc;
            nx     = '0;
            opened = cur;
            lc     = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_BIT : c;

            // whitespace after '<'; '?' or '!' kills the candidate
            if (cur[TRK_WS]) begin
                if (is_space(c))
                    nx[TRK_WS] = 1'b1;
                else if (c != CH_QMARK && c != CH_BANG)
                    opened[TRK_NAME] = 1'b1;
            end

            for (int k = 0; k < 4; k++) begin
                if (opened[TRK_NAME + k]) begin
                    if (c == CH_COLON)
                        nx[TRK_LOCAL] = 1'b1;
                    else if (is_term(c)) begin
                        if (k == 3)
                            found = 1'b1;
                    end else if (k < 3 && lc == name_char(k))
                        nx[TRK_NAME + k + 1] = 1'b1;
                    else
                        nx[TRK_BAD] = 1'b1;
                end
            end

            if (cur[TRK_BAD]) begin
                if (c == CH_COLON)
                    nx[TRK_LOCAL] = 1'b1;
                else if (!is_term(c))
                    nx[TRK_BAD] = 1'b1;
            end

            for (int k = 0; k < 4; k++) begin
                if (cur[TRK_LOCAL + k]) begin
                    if (is_term(c)) begin
                        if (k == 3)
                            found = 1'b1;
                    end else if (k < 3 && lc == name_char(k))
                        nx[TRK_LOCAL + k + 1] = 1'b1;
                end
            end
            return nx;
        endfunction

        // Note one accepted byte transaction
        function void note_byte(logic [7:0] c, logic lst);
            if (position < scan_limit) begin
                live = step_trackers(live, c);
                if (c == CH_LT)
                    live[TRK_WS] = 1'b1;
                position = position + 1'b1;
                // window close: a pending "svg" name counts as a match
                if (position == scan_limit || lst) begin
                    if (live[TRK_NAME + 3] || live[TRK_LOCAL + 3])
                        found = 1'b1;
                    live = '0;
                end
            end
            if (lst) begin
                verdicts_due.push_back(found);
                clear_buffer();
            end
        endfunction

        // Compare one accepted verdict transaction with the oldest prediction
        function void check_verdict(logic got);
            bit want;
            if (verdicts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected verdict is_svg=%0b", $realtime, got);
                return;
            end
            want = verdicts_due.pop_front();
            checked++;
            if (want)
                positives++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] verdict %0d: expected is_svg=%0b, got %0b",
                             $realtime, checked, want, got);
            end
        endfunction

        function int unsigned pending();
            return verdicts_due.size();
        endfunction

        function void flush_leftover();
            while (verdicts_due.size() != 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("missing verdict, expected is_svg=%0b", verdicts_due[0]);
                void'(verdicts_due.pop_front());
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels, block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;
    logic steady;
    logic rx_hold;
    int   phase_id;
    int unsigned cur_limit;
    int unsigned bytes_seen;
    int unsigned buffers_seen;
    int unsigned idle_cycles;
    logic [7:0]  bytes_q[$];
    verdict_board sb;

    svgts_cfg_if  cfg_ch();
    svgts_byte_if byte_ch();
    svgts_res_if  res_ch();

    svg_tag_sniffer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (byte_ch),
        .o_res   (res_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver: random idling, none while steady, idle throughout the hold-off
    always @(posedge clk) begin
        res_ch.ready <= !rx_hold && (steady || $urandom_range(99) >= 7);
    end

    // Hold off the verdict output for a long stretch in the pressure phase
    initial begin
        rx_hold <= 1'b0;
        wait (phase_id == 4);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Monitor all channels; feed the board and watch for a stalled run
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_limit(cfg_ch.data);
            if (byte_ch.valid && byte_ch.ready) begin
                sb.note_byte(byte_ch.data_byte, byte_ch.last_byte);
                bytes_seen++;
                if (byte_ch.last_byte)
                    buffers_seen++;
            end
            if (res_ch.valid && res_ch.ready)
                sb.check_verdict(res_ch.is_svg);
            if ((cfg_ch.valid && cfg_ch.ready) || (byte_ch.valid && byte_ch.ready)
                    || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_space();
        case ($urandom_range(3))
            0:       return CH_SP;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_term();
        case ($urandom_range(5))
            0:       return CH_GT;
            1:       return CH_SLASH;
            default: return pick_space();
        endcase
    endfunction

    function automatic logic [7:0] vary_case(logic [7:0] c);
        if (c >= CH_LO_A && c <= CH_LO_Z && $urandom_range(1))
            return c - CASE_BIT;
        return c;
    endfunction

    function automatic logic [7:0] any_letter();
        return vary_case(CH_LO_A + 8'($urandom_range(25)));
    endfunction

    function automatic void load_text(string s);
        for (int i = 0; i < s.len(); i++)
            bytes_q.push_back(s[i]);
    endfunction

    // Build a buffer of tag-like pieces mixed with raw noise
    function automatic void build_buffer();
        int unsigned cap;
        int unsigned pieces;
        cap = (cur_limit + 12 < MAX_BUF_LEN) ? cur_limit + 12 : MAX_BUF_LEN;
        pieces = $urandom_range(1, 4);
        bytes_q.delete();
        for (int p = 0; p < pieces; p++) begin
            if ($urandom_range(99) < 15) begin
                // raw noise over the full byte range
                repeat ($urandom_range(1, 6))
                    bytes_q.push_back(8'($urandom_range(255)));
                continue;
            end
            bytes_q.push_back(CH_LT);
            repeat ($urandom_range(0, 2))
                bytes_q.push_back(pick_space());
            if ($urandom_range(9) == 0)
                bytes_q.push_back($urandom_range(1) ? CH_QMARK : CH_BANG);
            // optional namespace prefix
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(0, 3))
                    bytes_q.push_back($urandom_range(1) ? vary_case(CH_S) : any_letter());
                bytes_q.push_back(CH_COLON);
                if ($urandom_range(19) == 0)
                    bytes_q.push_back(CH_COLON);
            end
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    bytes_q.push_back(vary_case(CH_S));
                    bytes_q.push_back(vary_case(CH_V));
                    bytes_q.push_back(vary_case(CH_G));
                end
                5: begin
                    bytes_q.push_back(vary_case(CH_S));
                    bytes_q.push_back(vary_case(CH_V));
                end
                6: begin
                    bytes_q.push_back(vary_case(CH_S));
                    bytes_q.push_back(vary_case(CH_V));
                    bytes_q.push_back(vary_case(CH_G));
                    bytes_q.push_back(vary_case(CH_G));
                end
                7: begin
                    bytes_q.push_back(any_letter());
                    bytes_q.push_back(vary_case(CH_V));
                    bytes_q.push_back(vary_case(CH_G));
                end
                8: begin
                    repeat ($urandom_range(1, 4))
                        bytes_q.push_back(any_letter());
                end
                default: ;
            endcase
            if ($urandom_range(9) < 7)
                bytes_q.push_back(pick_term());
        end
        if (bytes_q.size() == 0)
            bytes_q.push_back(8'($urandom_range(255)));
        while (bytes_q.size() > cap)
            void'(bytes_q.pop_back());
    endfunction

    // Offer one byte transaction and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while (!steady && $urandom_range(99) < 7) begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= lst;
        do @(posedge clk); while (!byte_ch.ready);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < bytes_q.size(); i++)
            send_byte(bytes_q[i], i == bytes_q.size() - 1);
        bytes_q.delete();
    endtask

    task automatic send_text(input string s);
        load_text(s);
        send_buffer();
    endtask

    // Drain outstanding verdicts, let the pipeline settle, then write the limit
    task automatic change_limit(input logic [SCAN_W-1:0] value);
        byte_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_limit = value;
        phase_id++;
    endtask

    // Random buffers until enough bytes have gone in
    task automatic run_random(input int unsigned budget);
        int unsigned sent;
        sent = 0;
        while (sent < budget) begin
            build_buffer();
            sent += bytes_q.size();
            send_buffer();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        phase_id     = 0;
        cur_limit    = SCAN_LIMIT_RESET;
        bytes_seen   = 0;
        buffers_seen = 0;
        idle_cycles  = 0;
        rst_n             <= 1'b0;
        steady            <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.last_byte <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Plain tag, '?' failure after a 0xFF byte, whitespace + prefix + case
        send_text("<svg>");
        bytes_q.push_back(8'hFF);
        send_text("<?s");
        send_text("< x:SvG/");
        // '!' failure after a zero byte, name still open at the last byte
        bytes_q.push_back(8'h00);
        send_text("<!x>");
        send_text("<sVg");
        run_random(220);

        // Tiny window: name closed by window end, then '<' as the window's last byte
        change_limit(4);
        send_text("<svgX>");
        send_text("abc<svg>");
        run_random(200);

        change_limit(1);
        run_random(60);

        // Widest window, no idling on either side
        change_limit(16'hFFFF);
        steady <= 1'b1;
        run_random(300);
        steady <= 1'b0;

        // Pressure phase: the receiver hold-off starts here
        change_limit(16);
        run_random(300);

        change_limit(3);
        run_random(200);

        change_limit(7);
        run_random(200);

        change_limit(SCAN_W'($urandom_range(2, 64)));
        run_random(200);

        // Wind down
        byte_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.flush_leftover();

        $display("Covered %0d bytes in %0d buffers over %0d scan limits",
                 bytes_seen, buffers_seen, phase_id + 1);
        $display("Checked %0d verdicts (%0d tag hits), %0d mismatches",
                 sb.checked, sb.positives, sb.mismatches);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/svgts_pkg.sv
rtl/svgts_byte_if.sv
rtl/svgts_res_if.sv
rtl/svgts_cfg_if.sv
rtl/svgts_front.sv
rtl/svgts_queue.sv
rtl/svgts_back.sv
rtl/svg_tag_sniffer.sv
verif/testbench.sv
